/* rtl/core/hidfrag_pkg.sv */
// hidfrag_pkg: shared types and constants of the hid message fragmenter
// transfer payload structs, opcode and register codes, microcode word layout
// no dependencies
`default_nettype none

package hidfrag_pkg;

   localparam int REPORT_BYTES_DEF = 64;

   // opcodes of an input transfer
   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_FLUSH = 2'd1;
   localparam logic [1:0] OP_BEGIN = 2'd2;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_ID     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_CODE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MESSAGE_LENGTH = 2'd2;

   // microprogram addresses
   localparam int UPC_W = 4;
   localparam logic [UPC_W-1:0] UPC_IDLE  = 4'd0;
   localparam logic [UPC_W-1:0] UPC_FIRST = 4'd1;
   localparam logic [UPC_W-1:0] UPC_DATA  = 4'd8;
   localparam logic [UPC_W-1:0] UPC_CONT  = 4'd9;
   localparam logic [UPC_W-1:0] UPC_PAD   = 4'd14;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] payload_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] report_byte;
      logic       report_end;
      logic       run_last;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      SRC_CID0,
      SRC_CID1,
      SRC_CID2,
      SRC_CID3,
      SRC_CMD,
      SRC_LEN_HI,
      SRC_LEN_LO,
      SRC_SEQ,
      SRC_DATA,
      SRC_ZERO
   } byte_src_type;

   typedef enum logic [1:0] {
      LAST_NEVER,
      LAST_ALWAYS,
      LAST_AT_END
   } last_mode_type;

   typedef enum logic [2:0] {
      NX_STEP,
      NX_DONE,
      NX_JUMP,
      NX_JUMP_FLUSH,
      NX_UNTIL_END
   } next_mode_type;

   typedef struct packed {
      byte_src_type     src;
      logic             emit;
      logic             seq_inc;
      last_mode_type    last_mode;
      next_mode_type    next;
      logic [UPC_W-1:0] target;
   } ucode_word_type;

   typedef struct packed {
      logic pos_zero;
      logic written;
      logic at_end;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/core/hidfrag_ucode_rom.sv */
// hidfrag_ucode_rom: read-only microprogram of the fragmenter
// one control word per step address; uses hidfrag_pkg
`default_nettype none

module hidfrag_ucode_rom
   import hidfrag_pkg::*;
(
   input  logic [UPC_W-1:0] upc,
   output ucode_word_type   ctl
);

   always_comb begin
      ctl = '{src: SRC_ZERO, emit: 1'b0, seq_inc: 1'b0, last_mode: LAST_NEVER,
              next: NX_DONE, target: UPC_IDLE};
      case (upc)
         // first report header
         4'd1: ctl = '{src: SRC_CID0, emit: 1'b1, seq_inc: 1'b0, last_mode: LAST_NEVER,
                       next: NX_STEP, target: UPC_IDLE};
         4'd2: ctl = '{src: SRC_CID1, emit: 1'b1, seq_inc: 1'b0, last_mode: LAST_NEVER,
                       next: NX_STEP, target: UPC_IDLE};
         4'd3: ctl = '{src: SRC_CID2, emit: 1'b1, seq_inc: 1'b0, last_mode: LAST_NEVER,
                       next: NX_STEP, target: UPC_IDLE};
         4'd4: ctl = '{src: SRC_CID3, emit: 1'b1, seq_inc: 1'b0, last_mode: LAST_NEVER,
                       next: NX_STEP, target: UPC_IDLE};
         4'd5: ctl = '{src: SRC_CMD, emit: 1'b1, seq_inc: 1'b0, last_mode: LAST_NEVER,
                       next: NX_STEP, target: UPC_IDLE};
         4'd6: ctl = '{src: SRC_LEN_HI, emit: 1'b1, seq_inc: 1'b0, last_mode: LAST_NEVER,
                       next: NX_STEP, target: UPC_IDLE};
         4'd7: ctl = '{src: SRC_LEN_LO, emit: 1'b1, seq_inc: 1'b0, last_mode: LAST_NEVER,
                       next: NX_JUMP_FLUSH, target: UPC_PAD};
         // payload byte
         4'd8: ctl = '{src: SRC_DATA, emit: 1'b1, seq_inc: 1'b0, last_mode: LAST_ALWAYS,
                       next: NX_DONE, target: UPC_IDLE};
         // continuation header
         4'd9: ctl = '{src: SRC_CID0, emit: 1'b1, seq_inc: 1'b0, last_mode: LAST_NEVER,
                       next: NX_STEP, target: UPC_IDLE};
         4'd10: ctl = '{src: SRC_CID1, emit: 1'b1, seq_inc: 1'b0, last_mode: LAST_NEVER,
                        next: NX_STEP, target: UPC_IDLE};
         4'd11: ctl = '{src: SRC_CID2, emit: 1'b1, seq_inc: 1'b0, last_mode: LAST_NEVER,
                        next: NX_STEP, target: UPC_IDLE};
         4'd12: ctl = '{src: SRC_CID3, emit: 1'b1, seq_inc: 1'b0, last_mode: LAST_NEVER,
                        next: NX_STEP, target: UPC_IDLE};
         4'd13: ctl = '{src: SRC_SEQ, emit: 1'b1, seq_inc: 1'b1, last_mode: LAST_NEVER,
                        next: NX_JUMP, target: UPC_DATA};
         // zero padding up to the end of the report
         4'd14: ctl = '{src: SRC_ZERO, emit: 1'b1, seq_inc: 1'b0, last_mode: LAST_AT_END,
                        next: NX_UNTIL_END, target: UPC_IDLE};
         default: ctl = '{src: SRC_ZERO, emit: 1'b0, seq_inc: 1'b0, last_mode: LAST_NEVER,
                          next: NX_DONE, target: UPC_IDLE};
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/hidfrag_sequencer.sv */
// hidfrag_sequencer: step counter, entry dispatch and conditional jumps
// uses hidfrag_pkg; driven by hidfrag_ucode_rom words and datapath status
`default_nettype none

module hidfrag_sequencer
   import hidfrag_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_opcode,
   input  dp_status_type    status,
   input  ucode_word_type   ctl,
   input  logic             advance,
   output logic             req_ready,
   output logic [UPC_W-1:0] upc
);

   logic [UPC_W-1:0] upc_ff, upc_in;
   logic             flush_ff, flush_in;
   logic [UPC_W-1:0] entry;

   assign upc       = upc_ff;
   assign req_ready = (upc_ff == UPC_IDLE);

   always_comb begin
      case (req_opcode)
         OP_BYTE:  entry = !status.pos_zero ? UPC_DATA :
                           (status.written ? UPC_CONT : UPC_FIRST);
         OP_FLUSH: entry = !status.pos_zero ? UPC_PAD :
                           (status.written ? UPC_IDLE : UPC_FIRST);
         default:  entry = UPC_IDLE;
      endcase
   end

   always_comb begin
      upc_in   = upc_ff;
      flush_in = flush_ff;
      if (upc_ff == UPC_IDLE) begin
         if (req_valid) begin
            upc_in   = entry;
            flush_in = (req_opcode == OP_FLUSH);
         end
      end else if (advance) begin
         case (ctl.next)
            NX_STEP:       upc_in = upc_ff + UPC_W'(1);
            NX_DONE:       upc_in = UPC_IDLE;
            NX_JUMP:       upc_in = ctl.target;
            NX_JUMP_FLUSH: upc_in = flush_ff ? ctl.target : upc_ff + UPC_W'(1);
            NX_UNTIL_END:  upc_in = status.at_end ? UPC_IDLE : upc_ff;
            default:       upc_in = UPC_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff   <= UPC_IDLE;
         flush_ff <= 1'b0;
      end else begin
         upc_ff   <= upc_in;
         flush_ff <= flush_in;
      end
   end

   // program counter stays inside the microprogram
   a_upc_range: assert property (@(posedge clock) disable iff (reset)
      upc_ff <= UPC_PAD)
      else $error("step counter outside microprogram");

   // padding holds its step until the report closes
   a_pad_hold: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == UPC_PAD) && advance && !status.at_end |=> upc_ff == UPC_PAD)
      else $error("padding left before end of report");

endmodule

`default_nettype wire

/* rtl/core/hidfrag_datapath.sv */
// hidfrag_datapath: configuration registers, report state, byte select, output register
// uses hidfrag_pkg; steered by hidfrag_ucode_rom control words
`default_nettype none

module hidfrag_datapath
   import hidfrag_pkg::*;
#(
   parameter int REPORT_BYTES = REPORT_BYTES_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data,
   input  logic                   req_accept,
   input  req_payload_type        req_payload,
   input  ucode_word_type         ctl,
   input  logic                   step_fire,
   input  logic                   rsp_ready,
   output logic                   slot_free,
   output dp_status_type          status,
   output logic                   rsp_valid,
   output rsp_payload_type        rsp_payload
);

   localparam int POS_W = $clog2(REPORT_BYTES);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(REPORT_BYTES - 1);

   logic [31:0]      channel_id_ff;
   logic [7:0]       command_code_ff;
   logic [15:0]      message_length_ff;
   logic [POS_W-1:0] pos_ff;
   logic             written_ff;
   logic [7:0]       seq_ff;
   logic [7:0]       data_ff;
   logic             rsp_valid_ff;
   rsp_payload_type  rsp_payload_ff;

   logic             emit;
   logic             at_end;
   logic [7:0]       byte_sel;

   assign at_end      = (pos_ff == POS_LAST);
   assign emit        = step_fire && ctl.emit;
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign status.pos_zero = (pos_ff == '0);
   assign status.written  = written_ff;
   assign status.at_end   = at_end;

   always_comb begin
      case (ctl.src)
         SRC_CID0:   byte_sel = channel_id_ff[7:0];
         SRC_CID1:   byte_sel = channel_id_ff[15:8];
         SRC_CID2:   byte_sel = channel_id_ff[23:16];
         SRC_CID3:   byte_sel = channel_id_ff[31:24];
         SRC_CMD:    byte_sel = command_code_ff;
         SRC_LEN_HI: byte_sel = message_length_ff[15:8];
         SRC_LEN_LO: byte_sel = message_length_ff[7:0];
         SRC_SEQ:    byte_sel = seq_ff;
         SRC_DATA:   byte_sel = data_ff;
         default:    byte_sel = 8'h00;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_id_ff     <= '0;
         command_code_ff   <= '0;
         message_length_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CHANNEL_ID:     channel_id_ff     <= csr_data;
            CSR_COMMAND_CODE:   command_code_ff   <= csr_data[7:0];
            CSR_MESSAGE_LENGTH: message_length_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // report state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         written_ff <= 1'b0;
         seq_ff     <= '0;
      end else if (req_accept) begin
         if (req_payload.opcode == OP_BEGIN) begin
            pos_ff     <= '0;
            written_ff <= 1'b0;
            seq_ff     <= '0;
         end else if (req_payload.opcode == OP_BYTE || req_payload.opcode == OP_FLUSH) begin
            written_ff <= 1'b1;
         end
      end else if (emit) begin
         pos_ff <= at_end ? '0 : pos_ff + POS_W'(1);
         if (ctl.seq_inc) begin
            seq_ff <= seq_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         data_ff <= req_payload.payload_byte;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_payload_ff.report_byte <= byte_sel;
         rsp_payload_ff.report_end  <= at_end;
         rsp_payload_ff.run_last    <= (ctl.last_mode == LAST_ALWAYS) ||
                                       ((ctl.last_mode == LAST_AT_END) && at_end);
      end
   end

   // a closed report restarts at position zero
   a_pos_wrap: assert property (@(posedge clock) disable iff (reset)
      emit && at_end |=> pos_ff == '0)
      else $error("position not cleared after last report byte");

   // sequence number steps once per continuation header
   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      emit && ctl.seq_inc |=> seq_ff == 8'($past(seq_ff) + 8'd1))
      else $error("sequence number did not advance");

   // a step only fires when the output register can take the byte
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      emit |-> slot_free)
      else $error("result register overwritten");

endmodule

`default_nettype wire

/* rtl/core/hid_message_fragmenter.sv */
// hid_message_fragmenter: top level, splits a message into fixed-size hid reports
// instantiates hidfrag_sequencer, hidfrag_ucode_rom, hidfrag_datapath; uses hidfrag_pkg
//
//   port group  direction  carries
//   req_*       in         opcode and payload byte, one transfer per item
//   rsp_*       out        report byte, report end, run last, one transfer per byte
//   csr_*       in         register index and write data
//
// one control word per cycle while the output register can take a byte: an item is
// taken in and then gives one control word per report byte it produces (payload byte 1,
// with header 6 or 8, flush up to REPORT_BYTES); begin and unused opcodes produce none
// the step counter waits whenever the single output register is held by rsp_ready low
// reset is synchronous and clears registers, report state and the step counter
`default_nettype none

module hid_message_fragmenter
   import hidfrag_pkg::*;
#(
   parameter int REPORT_BYTES = REPORT_BYTES_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   logic [UPC_W-1:0] upc;
   ucode_word_type   ctl;
   dp_status_type    status;
   logic             slot_free;
   logic             step_fire;

   assign csr_ready = 1'b1;
   assign step_fire = (upc != UPC_IDLE) && slot_free;

   hidfrag_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_payload.opcode),
      .status     (status),
      .ctl        (ctl),
      .advance    (slot_free),
      .req_ready  (req_ready),
      .upc        (upc)
   );

   hidfrag_ucode_rom u_rom (
      .upc (upc),
      .ctl (ctl)
   );

   hidfrag_datapath #(
      .REPORT_BYTES (REPORT_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_accept  (req_valid && req_ready),
      .req_payload (req_payload),
      .ctl         (ctl),
      .step_fire   (step_fire),
      .rsp_ready   (rsp_ready),
      .slot_free   (slot_free),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking testbench for hid_message_fragmenter, byte stream of hid reports
// predicts every report byte from the req and csr transfers and checks each rsp transfer
// depends on hidfrag_pkg and the hid_message_fragmenter rtl

import hidfrag_pkg::*;

localparam int FRAME_BYTES = REPORT_BYTES_DEF;
localparam int FIRST_HEADER_BYTES = 7;
localparam int CONT_HEADER_BYTES = 5;
localparam int MISMATCH_REPORTS = 10;
localparam logic [1:0] OP_UNUSED = 2'd3;
localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

class report_scoreboard;
   logic [31:0] channel_id;
   logic [7:0] command_code;
   logic [15:0] message_length;
   int unsigned report_fill;
   bit framed;
   logic [7:0] seq_no;
   rsp_payload_type pending[$];
   int unsigned mismatches;

   function new();
      channel_id = '0;
      command_code = '0;
      message_length = '0;
      report_fill = 0;
      framed = 1'b0;
      seq_no = '0;
      mismatches = 0;
   endfunction

   function void set_register(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] data);
      case (index)
         CSR_CHANNEL_ID: channel_id = data;
         CSR_COMMAND_CODE: command_code = data[7:0];
         CSR_MESSAGE_LENGTH: message_length = data[15:0];
         default: ;
      endcase
   endfunction

   function void push_byte(input logic [7:0] value, input bit ends);
      rsp_payload_type e;
      e.report_byte = value;
      e.report_end = ends;
      e.run_last = 1'b0;
      pending.push_back(e);
   endfunction

   function void push_channel_id();
      push_byte(channel_id[7:0], 1'b0);
      push_byte(channel_id[15:8], 1'b0);
      push_byte(channel_id[23:16], 1'b0);
      push_byte(channel_id[31:24], 1'b0);
   endfunction

   function void push_first_header();
      push_channel_id();
      push_byte(command_code, 1'b0);
      push_byte(message_length[15:8], 1'b0);
      push_byte(message_length[7:0], 1'b0);
      report_fill = FIRST_HEADER_BYTES;
   endfunction

   function void note_request(input req_payload_type req);
      int unsigned start_count;
      rsp_payload_type tail;
      start_count = pending.size();
      case (req.opcode)
         OP_BEGIN: begin
            report_fill = 0;
            framed = 1'b0;
            seq_no = '0;
         end
         OP_BYTE: begin
            if (report_fill == 0) begin
               if (!framed) begin
                  push_first_header();
               end else begin
                  push_channel_id();
                  push_byte(seq_no, 1'b0);
                  seq_no = seq_no + 8'd1;
                  report_fill = CONT_HEADER_BYTES;
               end
            end
            report_fill++;
            framed = 1'b1;
            if (report_fill >= FRAME_BYTES) begin
               push_byte(req.payload_byte, 1'b1);
               report_fill = 0;
            end else begin
               push_byte(req.payload_byte, 1'b0);
            end
         end
         OP_FLUSH: begin
            if (report_fill == 0 && !framed) push_first_header();
            while (report_fill != 0 && report_fill < FRAME_BYTES) begin
               report_fill++;
               push_byte(8'h00, report_fill == FRAME_BYTES);
            end
            report_fill = 0;
            framed = 1'b1;
         end
         default: ;
      endcase
      if (pending.size() > start_count) begin
         tail = pending.pop_back();
         tail.run_last = 1'b1;
         pending.push_back(tail);
      end
   endfunction

   function void check_response(input rsp_payload_type rsp);
      rsp_payload_type exp;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= MISMATCH_REPORTS)
            $display("unexpected rsp transfer: byte %h end %b last %b",
                     rsp.report_byte, rsp.report_end, rsp.run_last);
         return;
      end
      exp = pending.pop_front();
      if (rsp.report_byte !== exp.report_byte || rsp.report_end !== exp.report_end ||
          rsp.run_last !== exp.run_last) begin
         mismatches++;
         if (mismatches <= MISMATCH_REPORTS)
            $display("rsp mismatch: expected byte %h end %b last %b, got byte %h end %b last %b",
                     exp.report_byte, exp.report_end, exp.run_last,
                     rsp.report_byte, rsp.report_end, rsp.run_last);
      end
   endfunction
endclass

module tb;
   localparam int RANDOM_ITEMS = 220;
   localparam int SETTLE_CYCLES = 80;
   localparam int QUIET_LIMIT = 2000;
   localparam int CONT_REPORTS = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   report_scoreboard board;
   int unsigned items_sent = 0;
   int unsigned quiet_cycles = 0;
   bit steady = 1'b0;

   hid_message_fragmenter uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] corner_value(input int unsigned bits);
      logic [31:0] mask;
      int unsigned pick;
      mask = (bits >= 32) ? 32'hffff_ffff : ((32'd1 << bits) - 32'd1);
      pick = $urandom_range(0, 3);
      if (pick == 0) return 32'd0;
      if (pick == 1) return mask;
      return $urandom & mask;
   endfunction

   task automatic send_request(input logic [1:0] op, input logic [7:0] data);
      req_payload_type p;
      int unsigned gap;
      p.opcode = op;
      p.payload_byte = data;
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      if (op != OP_UNUSED) items_sent++;
      gap = steady ? 0 : idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(input logic [31:0] cid, input logic [7:0] cmd,
                                input logic [15:0] len);
      wait_drained();
      csr_write(CSR_CHANNEL_ID, cid);
      csr_write(CSR_COMMAND_CODE, {16'd0, 8'($urandom_range(0, 255)), cmd});
      csr_write(CSR_MESSAGE_LENGTH, {16'($urandom), len});
      csr_write(CSR_UNUSED, $urandom);
      csr_valid <= 1'b0;
   endtask

   task automatic send_message();
      int unsigned kind;
      int unsigned count;
      int unsigned r;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         // noise, unused opcodes included
         repeat ($urandom_range(1, 6)) send_request(2'($urandom_range(0, 3)), 8'($urandom));
      end else begin
         send_request(OP_BEGIN, 8'($urandom));
         r = $urandom_range(0, 9);
         count = (r < 4) ? $urandom_range(0, 8) :
                 (r < 8) ? $urandom_range(9, 70) : $urandom_range(100, 180);
         if (count > RANDOM_ITEMS - items_sent) count = RANDOM_ITEMS - items_sent;
         for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(0, 59) == 0) wait_drained();
            send_request(OP_BYTE, 8'($urandom));
         end
         // kind 2 leaves the report open for the next begin
         if (kind != 2) send_request(OP_FLUSH, 8'($urandom));
         if (kind == 3) begin
            repeat ($urandom_range(1, 12)) send_request(OP_BYTE, 8'($urandom));
            send_request(OP_FLUSH, 8'($urandom));
            send_request(OP_FLUSH, 8'($urandom));
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.set_register(csr_index, csr_data);
         if (req_valid && req_ready) board.note_request(req_payload);
         if (rsp_valid && rsp_ready) board.check_response(rsp_payload);
         if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      int unsigned hold;
      int unsigned gap;
      repeat (6) @(posedge clock);
      forever begin
         hold = ($urandom_range(0, 6) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (hold) @(posedge clock);
         gap = idle_length();
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty message, flush with nothing open, continuation, abandon
      load_settings(32'h0403_0201, 8'h86, 16'h1234);
      send_request(OP_FLUSH, 8'h00);
      send_request(OP_FLUSH, 8'hff);
      send_request(OP_BYTE, 8'hff);
      send_request(OP_UNUSED, 8'hff);
      send_request(OP_FLUSH, 8'h00);
      send_request(OP_BEGIN, 8'h00);
      send_request(OP_BYTE, 8'h00);
      send_request(OP_BYTE, 8'h5a);
      send_request(OP_BEGIN, 8'hff);
      send_request(OP_BEGIN, 8'h00);
      send_request(OP_FLUSH, 8'h00);
      load_settings(32'hffff_ffff, 8'hff, 16'hffff);
      send_request(OP_BEGIN, 8'h00);
      send_request(OP_BYTE, 8'hff);
      send_request(OP_BYTE, 8'h80);
      send_request(OP_FLUSH, 8'h00);
      send_request(OP_BYTE, 8'h01);
      send_request(OP_FLUSH, 8'h00);
      send_request(OP_FLUSH, 8'h00);
      load_settings(32'h0, 8'h00, 16'h0000);
      send_request(OP_BEGIN, 8'h00);
      send_request(OP_FLUSH, 8'h00);
      send_request(OP_UNUSED, 8'h00);

      // continuation reports, one byte each
      load_settings(corner_value(32), 8'(corner_value(8)), 16'(corner_value(16)));
      steady = 1'b0;
      send_request(OP_BEGIN, 8'($urandom));
      repeat (CONT_REPORTS) begin
         send_request(OP_BYTE, 8'($urandom));
         send_request(OP_FLUSH, 8'($urandom));
      end

      for (int unsigned phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
         if (phase % 4 == 0)
            load_settings(corner_value(32), 8'(corner_value(8)), 16'(corner_value(16)));
         steady = ($urandom_range(0, 3) == 0);
         send_message();
      end

      wait_drained();
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
